FILE: sv/i2cem_pkg.sv
// ----------------------------------------------------------------------------
// i2cem_pkg
// Types and constants shared by the I2C EEPROM master unit.
// ----------------------------------------------------------------------------
package i2cem_pkg;

  typedef enum logic [14:0] {
    PH_IDLE   = 15'b000000000000001,
    PH_OPEN   = 15'b000000000000010,
    PH_START  = 15'b000000000000100,
    PH_CTRLW  = 15'b000000000001000,
    PH_ACKC   = 15'b000000000010000,
    PH_ADDR   = 15'b000000000100000,
    PH_ACKA   = 15'b000000001000000,
    PH_DATA   = 15'b000000010000000,
    PH_ACKD   = 15'b000000100000000,
    PH_RSTART = 15'b000001000000000,
    PH_CTRLR  = 15'b000010000000000,
    PH_ACKR   = 15'b000100000000000,
    PH_RPRE   = 15'b001000000000000,
    PH_READ   = 15'b010000000000000,
    PH_STOP   = 15'b100000000000000
  } phase_t;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_DELAY_TICKS    = 2'd1;
  localparam logic [1:0] CFG_ACK_WAIT_LIMIT = 2'd2;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET = 8'd160;
  localparam logic [15:0] DELAY_TICKS_RESET    = 16'd1;
  localparam logic [7:0]  ACK_WAIT_LIMIT_RESET = 8'd255;

  localparam int MEM_ADDRESS_W = 11;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 16;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] READ_BIT      = 8'h01;

endpackage

FILE: sv/i2c_eeprom_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_master_unit
// Bit-level I2C master for a 24C16-type serial EEPROM, one bus tick per beat.
// ----------------------------------------------------------------------------
// Every input beat is one timing tick of the bus sequencer. It carries the
// sampled SDA level and may carry a write or random-read request. Every input
// beat yields exactly one output beat with the SCL and SDA line levels, the
// busy and done flags, the last read byte and the missing-acknowledge flag.
// The result of a beat appears on the output in the cycle after it is taken, and
// a new beat is taken in every cycle while the receiver keeps up, so the block
// runs at one beat per clock when not stalled, each result held in m_tdata.
// Bus timing is counted in ticks, not clocks: each step of the bus waveform
// lasts delay_ticks input beats, however the beats are spaced in time.
// When the receiver stalls, the finished beat waits in the output register and
// s_tready drops until it is taken; no beat is lost or repeated.
// Reset returns the sequencer to idle with SCL high and SDA driven high, and
// loads the configuration registers with defaults. The user must write them
// via cfg_we, cfg_index and cfg_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_unit #(
  parameter int ADDR_BITS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sda_in, req_valid, mem_address[10:0], write_data[7:0], keep_open, zero pad
  input  logic [23:0] s_tdata,
  // req_type
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl, sda_out, sda_drive, busy_res, done_res, read_data[7:0], ack_missing,
  // zero pad
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = i2cem_pkg::MEM_ADDRESS_W;

  logic [7:0]  device_address;
  logic [15:0] delay_ticks;
  logic [7:0]  ack_wait_limit;

  i2cem_pkg::phase_t phase, phase_next;
  logic [1:0]  sub_step, sub_step_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  ack_wait_count, ack_wait_count_next;
  logic [ADDR_BITS-1:0] held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic [7:0]  read_byte_reg, read_byte_reg_next;
  logic        held_read, held_read_next;
  logic        open_write, open_write_next;
  logic        ack_fail_flag, ack_fail_flag_next;
  logic        line_scl, line_scl_next;
  logic        line_sda, line_sda_next;
  logic        line_drv, line_drv_next;

  logic        sda_in, req_valid, req_type, keep_open;
  logic [AW-1:0] mem_address;
  logic [7:0]  write_data;
  logic        accept, done, do_apply;
  logic [15:0] unit_ticks;
  logic [16:0] count_plus;
  logic [AW-1:0] addr_wide;
  logic [7:0]  control_byte;
  logic        busy_next;

  assign sda_in      = s_tdata[0];
  assign req_valid   = s_tdata[1];
  assign mem_address = s_tdata[12:2];
  assign write_data  = s_tdata[20:13];
  assign keep_open   = s_tdata[21];
  assign req_type    = s_tuser;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign unit_ticks   = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
  assign count_plus   = {1'b0, delay_count} + 17'd1;
  assign addr_wide    = AW'(held_address);
  assign control_byte = device_address | {4'b0000, addr_wide[10:8], 1'b0};

  always_comb begin
    phase_next          = phase;
    sub_step_next       = sub_step;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    delay_count_next    = delay_count;
    ack_wait_count_next = ack_wait_count;
    held_address_next   = held_address;
    held_data_next      = held_data;
    read_byte_reg_next  = read_byte_reg;
    held_read_next      = held_read;
    open_write_next     = open_write;
    ack_fail_flag_next  = ack_fail_flag;
    line_scl_next       = line_scl;
    line_sda_next       = line_sda;
    line_drv_next       = line_drv;
    done                = 1'b0;
    do_apply            = 1'b0;

    if (phase == i2cem_pkg::PH_IDLE) begin
      if (req_valid) begin
        held_address_next   = ADDR_BITS'(mem_address);
        held_data_next      = write_data;
        held_read_next      = req_type;
        open_write_next     = !req_type && keep_open;
        ack_fail_flag_next  = 1'b0;
        delay_count_next    = 16'd0;
        phase_next          = i2cem_pkg::PH_START;
        sub_step_next       = 2'd0;
        bit_count_next      = 4'd0;
        ack_wait_count_next = 8'd0;
        shift_byte_next     = 8'd0;
        do_apply            = 1'b1;
      end
    end else if (phase == i2cem_pkg::PH_OPEN) begin
      if (req_valid && !req_type) begin
        held_data_next      = write_data;
        open_write_next     = keep_open;
        ack_fail_flag_next  = 1'b0;
        delay_count_next    = 16'd0;
        phase_next          = i2cem_pkg::PH_DATA;
        sub_step_next       = 2'd0;
        bit_count_next      = 4'd0;
        ack_wait_count_next = 8'd0;
        shift_byte_next     = write_data;
        do_apply            = 1'b1;
      end
    end else if (count_plus >= {1'b0, unit_ticks}) begin
      delay_count_next = 16'd0;
      do_apply         = 1'b1;
      unique case (phase)
        i2cem_pkg::PH_START, i2cem_pkg::PH_RSTART: begin
          if (sub_step != 2'd3) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            phase_next          = (phase == i2cem_pkg::PH_START) ?
                                  i2cem_pkg::PH_CTRLW : i2cem_pkg::PH_CTRLR;
            sub_step_next       = 2'd0;
            bit_count_next      = 4'd0;
            ack_wait_count_next = 8'd0;
            shift_byte_next     = (phase == i2cem_pkg::PH_START) ? control_byte :
                                  (control_byte | i2cem_pkg::READ_BIT);
          end
        end
        i2cem_pkg::PH_CTRLW, i2cem_pkg::PH_ADDR, i2cem_pkg::PH_DATA,
        i2cem_pkg::PH_CTRLR: begin
          if (bit_count < i2cem_pkg::BITS_PER_BYTE) begin
            if (sub_step < 2'd2) begin
              sub_step_next = sub_step + 2'd1;
            end else begin
              bit_count_next = bit_count + 4'd1;
              sub_step_next  = 2'd0;
            end
          end else if (sub_step == 2'd0) begin
            sub_step_next = 2'd1;
          end else begin
            unique case (phase)
              i2cem_pkg::PH_CTRLW: phase_next = i2cem_pkg::PH_ACKC;
              i2cem_pkg::PH_ADDR:  phase_next = i2cem_pkg::PH_ACKA;
              i2cem_pkg::PH_DATA:  phase_next = i2cem_pkg::PH_ACKD;
              default:             phase_next = i2cem_pkg::PH_ACKR;
            endcase
            sub_step_next       = 2'd0;
            bit_count_next      = 4'd0;
            ack_wait_count_next = 8'd0;
          end
        end
        i2cem_pkg::PH_ACKC, i2cem_pkg::PH_ACKA, i2cem_pkg::PH_ACKD,
        i2cem_pkg::PH_ACKR: begin
          if (sub_step == 2'd0) begin
            if (!sda_in) begin
              sub_step_next = 2'd1;
            end else if (ack_wait_count < ack_wait_limit) begin
              ack_wait_count_next = ack_wait_count + 8'd1;
            end else begin
              ack_fail_flag_next = 1'b1;
              sub_step_next      = 2'd1;
            end
          end else begin
            sub_step_next       = 2'd0;
            bit_count_next      = 4'd0;
            ack_wait_count_next = 8'd0;
            shift_byte_next     = 8'd0;
            unique case (phase)
              i2cem_pkg::PH_ACKC: begin
                phase_next      = i2cem_pkg::PH_ADDR;
                shift_byte_next = addr_wide[7:0];
              end
              i2cem_pkg::PH_ACKA: begin
                if (held_read) begin
                  phase_next = i2cem_pkg::PH_RSTART;
                end else begin
                  phase_next      = i2cem_pkg::PH_DATA;
                  shift_byte_next = held_data;
                end
              end
              i2cem_pkg::PH_ACKD: begin
                if (open_write) begin
                  phase_next = i2cem_pkg::PH_OPEN;
                  done       = 1'b1;
                end else begin
                  phase_next = i2cem_pkg::PH_STOP;
                end
              end
              default: phase_next = i2cem_pkg::PH_RPRE;
            endcase
          end
        end
        i2cem_pkg::PH_RPRE: begin
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            phase_next          = i2cem_pkg::PH_READ;
            sub_step_next       = 2'd0;
            bit_count_next      = 4'd0;
            ack_wait_count_next = 8'd0;
            shift_byte_next     = 8'd0;
          end
        end
        i2cem_pkg::PH_READ: begin
          if (sub_step == 2'd0) begin
            shift_byte_next = {shift_byte[6:0], sda_in};
            sub_step_next   = 2'd1;
          end else if (bit_count < 4'd7) begin
            bit_count_next = bit_count + 4'd1;
            sub_step_next  = 2'd0;
          end else begin
            read_byte_reg_next  = shift_byte;
            phase_next          = i2cem_pkg::PH_STOP;
            sub_step_next       = 2'd0;
            bit_count_next      = 4'd0;
            ack_wait_count_next = 8'd0;
          end
        end
        default: begin
          if (sub_step < 2'd2) begin
            sub_step_next = sub_step + 2'd1;
          end else begin
            phase_next          = i2cem_pkg::PH_IDLE;
            sub_step_next       = 2'd0;
            bit_count_next      = 4'd0;
            ack_wait_count_next = 8'd0;
            done                = 1'b1;
          end
        end
      endcase
    end else begin
      delay_count_next = count_plus[15:0];
    end

    if (do_apply) begin
      unique case (phase_next)
        i2cem_pkg::PH_IDLE: begin
          line_scl_next = 1'b1;
          line_sda_next = 1'b1;
          line_drv_next = 1'b1;
        end
        i2cem_pkg::PH_OPEN: begin
          line_scl_next = 1'b0;
          line_sda_next = 1'b1;
          line_drv_next = 1'b1;
        end
        i2cem_pkg::PH_START, i2cem_pkg::PH_RSTART: begin
          line_drv_next = 1'b1;
          unique case (sub_step_next)
            2'd0:    line_sda_next = 1'b1;
            2'd1:    line_scl_next = 1'b1;
            2'd2:    line_sda_next = 1'b0;
            default: line_scl_next = 1'b0;
          endcase
        end
        i2cem_pkg::PH_CTRLW, i2cem_pkg::PH_ADDR, i2cem_pkg::PH_DATA,
        i2cem_pkg::PH_CTRLR: begin
          line_drv_next = 1'b1;
          if (sub_step_next == 2'd0) begin
            line_scl_next = 1'b0;
          end else if (sub_step_next == 2'd1) begin
            line_sda_next = (bit_count_next < i2cem_pkg::BITS_PER_BYTE) ?
                            shift_byte_next[3'(3'd7 - bit_count_next[2:0])] : 1'b1;
          end else begin
            line_scl_next = 1'b1;
          end
        end
        i2cem_pkg::PH_ACKC, i2cem_pkg::PH_ACKA, i2cem_pkg::PH_ACKD,
        i2cem_pkg::PH_ACKR, i2cem_pkg::PH_READ: begin
          line_drv_next = 1'b0;
          line_scl_next = (sub_step_next == 2'd0);
        end
        i2cem_pkg::PH_RPRE: begin
          if (sub_step_next == 2'd0) begin
            line_scl_next = 1'b0;
            line_drv_next = 1'b1;
          end else if (sub_step_next == 2'd1) begin
            line_sda_next = 1'b1;
          end else begin
            line_drv_next = 1'b0;
          end
        end
        default: begin
          line_drv_next = 1'b1;
          if (sub_step_next == 2'd0) begin
            line_sda_next = 1'b0;
          end else if (sub_step_next == 2'd1) begin
            line_scl_next = 1'b1;
          end else begin
            line_sda_next = 1'b1;
          end
        end
      endcase
    end
  end

  assign busy_next = (phase_next != i2cem_pkg::PH_IDLE) &&
                     (phase_next != i2cem_pkg::PH_OPEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cem_pkg::DEVICE_ADDRESS_RESET;
      delay_ticks    <= i2cem_pkg::DELAY_TICKS_RESET;
      ack_wait_limit <= i2cem_pkg::ACK_WAIT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cem_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        i2cem_pkg::CFG_DELAY_TICKS:    delay_ticks    <= cfg_data;
        i2cem_pkg::CFG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cem_pkg::PH_IDLE;
      sub_step       <= 2'd0;
      bit_count      <= 4'd0;
      shift_byte     <= 8'd0;
      delay_count    <= 16'd0;
      ack_wait_count <= 8'd0;
      held_address   <= '0;
      held_data      <= 8'd0;
      read_byte_reg  <= 8'd0;
      held_read      <= 1'b0;
      open_write     <= 1'b0;
      ack_fail_flag  <= 1'b0;
      line_scl       <= 1'b1;
      line_sda       <= 1'b1;
      line_drv       <= 1'b1;
    end else if (accept) begin
      phase          <= phase_next;
      sub_step       <= sub_step_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      delay_count    <= delay_count_next;
      ack_wait_count <= ack_wait_count_next;
      held_address   <= held_address_next;
      held_data      <= held_data_next;
      read_byte_reg  <= read_byte_reg_next;
      held_read      <= held_read_next;
      open_write     <= open_write_next;
      ack_fail_flag  <= ack_fail_flag_next;
      line_scl       <= line_scl_next;
      line_sda       <= line_sda_next;
      line_drv       <= line_drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, ack_fail_flag_next, read_byte_reg_next, done, busy_next,
                  line_drv_next, line_sda_next, line_scl_next};
    end
  end

endmodule
